>>> hw/rtl/tor_pkg.sv
// Shared types and constants for the tree ORAM controller.
package tor_pkg;

  localparam logic [31:0] LFSR_TAPS = 32'hD000_0001;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic REG_RANDOM_SEED = 1'b0;

  typedef struct packed {
    logic        load;
    logic        step;
    logic [31:0] seed;
  } draw_ctl_t;

  typedef enum logic [15:0] {
    ST_CLR      = 16'h0001,
    ST_IDLE     = 16'h0002,
    ST_MOD      = 16'h0004,
    ST_MAP_RD   = 16'h0008,
    ST_MAP_CHK  = 16'h0010,
    ST_SRCH_RD  = 16'h0020,
    ST_SRCH_CHK = 16'h0040,
    ST_NEWLEAF  = 16'h0080,
    ST_INS_RD   = 16'h0100,
    ST_INS_CHK  = 16'h0200,
    ST_EV_RD    = 16'h0400,
    ST_EV_CHK   = 16'h0800,
    ST_EV_DONE  = 16'h1000,
    ST_PICK_A   = 16'h2000,
    ST_PICK_B   = 16'h4000,
    ST_OUT      = 16'h8000
  } state_t;

endpackage

>>> hw/rtl/tor_ram.sv
// Generic single-port RAM with registered read.
module tor_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> hw/rtl/tor_lfsr.sv
// Galois LFSR used for every random draw.
module tor_lfsr
  import tor_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  draw_ctl_t   ctl,
  output logic [31:0] nxt
);

  logic [31:0] lfsr;

  assign nxt = (lfsr >> 1) ^ (lfsr[0] ? LFSR_TAPS : 32'h0);

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr <= 32'h1;
    end else if (ctl.load) begin
      lfsr <= (ctl.seed == 32'h0) ? 32'h1 : ctl.seed;
    end else if (ctl.step) begin
      lfsr <= nxt;
    end
  end

endmodule

>>> hw/rtl/tree_oram_controller.sv
// Tree ORAM controller: sequencer over one slot RAM, one map RAM and the LFSR.
// After reset a clearing pass over max(bucket slots, BLOCK_COUNT) addresses runs with
// s_axis_tready low; the seed register resets to 1.
// Beat to result: map lookup, path search slot by slot, new leaf, a root insert (writes and
// hits only), then 11 evictions and 10 picks, where a pick equal to the last node is redrawn.
// One access at a time; the next beat is taken the cycle after the result beat.
module tree_oram_controller
  import tor_pkg::*;
#(
  parameter int LEAF_COUNT       = 64,
  parameter int SLOTS_PER_BUCKET = 4,
  parameter int BLOCK_COUNT      = 256,
  parameter int PAYLOAD_BITS     = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // block_id[7:0], write_data[71:8]
  input  logic [0:0]  s_axis_tuser,   // cmd[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // read_data[63:0], assigned_leaf[69:64], zero
  output logic [1:0]  m_axis_tuser,   // found[0], dropped[1]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int LW    = $clog2(LEAF_COUNT);
  localparam int NODES = 2 * LEAF_COUNT - 1;
  localparam int NW    = $clog2(NODES);
  localparam int STOT  = NODES * SLOTS_PER_BUCKET;
  localparam int SAW   = $clog2(STOT);
  localparam int IDW   = $clog2(BLOCK_COUNT);
  localparam int SW    = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int LVW   = $clog2(LW + 1);
  localparam int IXW   = $clog2(LW);
  localparam int SWD   = 1 + IDW + LW + PAYLOAD_BITS;
  localparam int MWD   = 1 + LW;
  localparam int CLR_N = (STOT > BLOCK_COUNT) ? STOT : BLOCK_COUNT;
  localparam int CW    = $clog2(CLR_N + 1);

  state_t state;

  logic [31:0]             seed;
  logic [CW-1:0]           cnt;
  logic                    cmd;
  logic [7:0]              idr;
  logic [PAYLOAD_BITS-1:0] data;
  logic [PAYLOAD_BITS-1:0] rd;
  logic                    found;
  logic                    dropped;
  logic [LW-1:0]           leaf;
  logic [LW-1:0]           new_leaf;
  logic [NW-1:0]           node;
  logic [NW-1:0]           anode;
  logic [LVW-1:0]          lvl;
  logic [SW-1:0]           slot;
  logic                    pick;
  logic                    ins_root;
  logic [IDW-1:0]          ins_blk;
  logic [LW-1:0]           ins_leaf;
  logic [PAYLOAD_BITS-1:0] ins_pay;

  logic [IDW-1:0]          id;
  logic                    cfg_wr;
  draw_ctl_t               draw;
  logic [31:0]             nxt;

  logic                    slot_we;
  logic [SAW-1:0]          slot_addr;
  logic [SWD-1:0]          slot_wdata;
  logic [SWD-1:0]          slot_rdata;
  logic                    map_we;
  logic [IDW-1:0]          map_addr;
  logic [MWD-1:0]          map_wdata;
  logic [MWD-1:0]          map_rdata;

  logic                    w_valid;
  logic [IDW-1:0]          w_blk;
  logic [LW-1:0]           w_leaf;
  logic [PAYLOAD_BITS-1:0] w_pay;
  logic                    last_slot;
  logic [NW-1:0]           low;
  logic [NW-1:0]           cand;

  function automatic logic [NW-1:0] child(input logic [NW-1:0] n, input logic [LVW-1:0] l,
                                          input logic [LW-1:0] lf);
    logic b;
    b = lf[IXW'(LW - 1) - IXW'(l)];
    return NW'({n[NW-2:0], 1'b0}) + NW'(1) + NW'(b);
  endfunction

  assign id        = IDW'(idr);
  assign w_valid   = slot_rdata[0];
  assign w_blk     = slot_rdata[IDW:1];
  assign w_leaf    = slot_rdata[IDW+LW:IDW+1];
  assign w_pay     = slot_rdata[SWD-1:IDW+LW+1];
  assign last_slot = (slot == SW'(SLOTS_PER_BUCKET - 1));
  assign low       = NW'((NW'(1) << lvl) - NW'(1));
  assign cand      = low + (nxt[NW-1:0] & low);

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_RANDOM_SEED);
  assign prdata = (paddr[2] == REG_RANDOM_SEED) ? seed : 32'h0;

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata  = {2'b00, 6'(new_leaf), 64'(rd)};
  assign m_axis_tuser  = {dropped, found};

  always_comb begin
    draw.load = cfg_wr;
    draw.seed = pwdata;
    draw.step = 1'b0;
    case (state)
      ST_MAP_CHK: draw.step = !map_rdata[LW] && (cmd == CMD_WRITE);
      ST_NEWLEAF, ST_PICK_A, ST_PICK_B: draw.step = 1'b1;
      default: draw.step = 1'b0;
    endcase
  end

  always_comb begin
    slot_we    = 1'b0;
    slot_wdata = '0;
    slot_addr  = SAW'(32'(node) * 32'(SLOTS_PER_BUCKET) + 32'(slot));
    map_we     = 1'b0;
    map_addr   = id;
    map_wdata  = {1'b1, new_leaf};
    case (state)
      ST_CLR: begin
        slot_addr = SAW'(cnt);
        slot_we   = (32'(cnt) < 32'(STOT));
        map_addr  = IDW'(cnt);
        map_we    = (32'(cnt) < 32'(BLOCK_COUNT));
        map_wdata = '0;
      end
      ST_SRCH_CHK: slot_we = w_valid && (w_blk == id);
      ST_EV_CHK:   slot_we = w_valid;
      ST_INS_CHK: begin
        slot_we    = !w_valid;
        slot_wdata = {ins_pay, ins_leaf, ins_blk, 1'b1};
      end
      ST_NEWLEAF: begin
        map_we    = 1'b1;
        map_wdata = {1'b1, nxt[LW-1:0]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= 32'h1;
    end else if (cfg_wr) begin
      seed <= pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR;
      cnt   <= '0;
    end else begin
      case (state)
        ST_CLR: begin
          cnt <= cnt + CW'(1);
          if (32'(cnt) == CLR_N - 1) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            cmd     <= s_axis_tuser[0];
            idr     <= s_axis_tdata[7:0];
            data    <= PAYLOAD_BITS'(s_axis_tdata[71:8]);
            rd      <= '0;
            found   <= 1'b0;
            dropped <= 1'b0;
            state   <= ST_MOD;
          end
        end
        ST_MOD: begin
          if (32'(idr) >= 32'(BLOCK_COUNT)) idr <= idr - 8'(BLOCK_COUNT);
          else state <= ST_MAP_RD;
        end
        ST_MAP_RD: state <= ST_MAP_CHK;
        ST_MAP_CHK: begin
          node <= '0;
          lvl  <= '0;
          slot <= '0;
          if (map_rdata[LW]) begin
            leaf  <= map_rdata[LW-1:0];
            state <= ST_SRCH_RD;
          end else if (cmd == CMD_WRITE) begin
            leaf  <= nxt[LW-1:0];
            state <= ST_SRCH_RD;
          end else begin
            state <= ST_NEWLEAF;
          end
        end
        ST_SRCH_RD: state <= ST_SRCH_CHK;
        ST_SRCH_CHK: begin
          if (w_valid && (w_blk == id)) begin
            found <= 1'b1;
            rd    <= w_pay;
          end
          if ((w_valid && (w_blk == id)) || last_slot) begin
            slot <= '0;
            if (lvl == LVW'(LW)) begin
              state <= ST_NEWLEAF;
            end else begin
              node  <= child(node, lvl, leaf);
              lvl   <= lvl + LVW'(1);
              state <= ST_SRCH_RD;
            end
          end else begin
            slot  <= slot + SW'(1);
            state <= ST_SRCH_RD;
          end
        end
        ST_NEWLEAF: begin
          new_leaf <= nxt[LW-1:0];
          ins_blk  <= id;
          ins_leaf <= nxt[LW-1:0];
          ins_pay  <= (cmd == CMD_WRITE) ? data : rd;
          node     <= '0;
          lvl      <= '0;
          slot     <= '0;
          pick     <= 1'b0;
          ins_root <= 1'b1;
          state    <= ((cmd == CMD_WRITE) || found) ? ST_INS_RD : ST_EV_RD;
        end
        ST_INS_RD: state <= ST_INS_CHK;
        ST_INS_CHK: begin
          if (!w_valid || last_slot) begin
            if (w_valid) dropped <= 1'b1;
            slot <= '0;
            if (ins_root) begin
              ins_root <= 1'b0;
              node     <= '0;
              state    <= ST_EV_RD;
            end else begin
              state <= ST_EV_DONE;
            end
          end else begin
            slot  <= slot + SW'(1);
            state <= ST_INS_RD;
          end
        end
        ST_EV_RD: state <= ST_EV_CHK;
        ST_EV_CHK: begin
          if (w_valid) begin
            ins_blk  <= w_blk;
            ins_leaf <= w_leaf;
            ins_pay  <= w_pay;
            node     <= child(node, lvl, w_leaf);
            slot     <= '0;
            state    <= ST_INS_RD;
          end else if (last_slot) begin
            state <= ST_EV_DONE;
          end else begin
            slot  <= slot + SW'(1);
            state <= ST_EV_RD;
          end
        end
        ST_EV_DONE: begin
          if (lvl == '0) begin
            lvl   <= LVW'(1);
            state <= ST_PICK_A;
          end else if (!pick) begin
            state <= ST_PICK_B;
          end else if (lvl == LVW'(LW - 1)) begin
            state <= ST_OUT;
          end else begin
            lvl   <= lvl + LVW'(1);
            state <= ST_PICK_A;
          end
        end
        ST_PICK_A: begin
          node  <= cand;
          anode <= cand;
          pick  <= 1'b0;
          slot  <= '0;
          state <= ST_EV_RD;
        end
        ST_PICK_B: begin
          if (cand != anode) begin
            node  <= cand;
            pick  <= 1'b1;
            slot  <= '0;
            state <= ST_EV_RD;
          end
        end
        ST_OUT: begin
          if (m_axis_tready) state <= ST_IDLE;
        end
        default: state <= ST_CLR;
      endcase
    end
  end

  tor_lfsr u_lfsr (
    .clk (clk),
    .rst (rst),
    .ctl (draw),
    .nxt (nxt)
  );

  tor_ram #(.WIDTH(SWD), .DEPTH(STOT)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .addr  (slot_addr),
    .wdata (slot_wdata),
    .rdata (slot_rdata)
  );

  tor_ram #(.WIDTH(MWD), .DEPTH(BLOCK_COUNT)) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .addr  (map_addr),
    .wdata (map_wdata),
    .rdata (map_rdata)
  );

endmodule

>>> hw/rtl/tor_checker.sv
// Port-level checker for the tree ORAM controller, bound to the top level.
module tor_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while a result is pending");

  a_in_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !m_axis_tvalid)
    else $error("block not busy after accepting a beat");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready |=> s_axis_tready && !m_axis_tvalid)
    else $error("block not free after result beat");

  a_not_found: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[63:0] == 64'h0)
    else $error("read data nonzero on a miss");

endmodule

bind tree_oram_controller tor_checker u_tor_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
